[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property that must also hold during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[hw/rtl/lms_anc_pkg.sv]
// ----------------------------------------------------------------------------
// lms_anc_pkg
// shared types for the lms noise canceller: item structs, fsm states and
// the control bundle that drives the tap cells
// ----------------------------------------------------------------------------
package lms_anc_pkg;

   localparam logic [15:0] STEP_SIZE_RESET = 16'd328;

   typedef struct packed {
      logic signed [15:0] primary_sample;
      logic signed [15:0] reference_sample;
   } lms_req_type;

   typedef struct packed {
      logic signed [15:0] error_sample;
      logic               frame_done;
      logic        [30:0] frame_mean_sq_error;
   } lms_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRED,
      ST_DRAIN,
      ST_ERR,
      ST_MUL,
      ST_UPD_MUL,
      ST_UPD_WR,
      ST_DONE
   } lms_state_type;

   // per cycle commands to every tap cell
   typedef struct packed {
      logic shift;   // new reference enters, history moves up one place
      logic rotate;  // ring moves one place towards the head
   } lms_cell_ctl_type;

endpackage

[hw/rtl/lms_adaptive_noise_canceller_core.sv]
// each item rotates the tap ring once past the shared mac to predict and once past
// the update multiplier to update, in states ST_UPD_MUL and ST_UPD_WR; req_stall
// holds off a new item until the sequencer is back in ST_IDLE
// a new item is taken while the previous result still waits in the output register
// synchronous reset clears weights, history, frame counter, sum; step_size to 328
// ----------------------------------------------------------------------------
// lms_adaptive_noise_canceller_core
// lms noise canceller: ring of tap cells circulating past one shared mac
// ----------------------------------------------------------------------------
module lms_adaptive_noise_canceller_core
   import lms_anc_pkg::*;
#(
   parameter int TAPS      = 32,
   parameter int FRAME_LEN = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lms_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output lms_rsp_type rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

`include "assert_macros.svh"

   localparam int TC_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W  = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
   localparam int ACC_W  = 49 + $clog2(TAPS);
   localparam int MEAN_SH = $clog2(FRAME_LEN + 1) - 1;

   // tap ring
   lms_cell_ctl_type   cell_ctl;
   logic signed [15:0] hist_q [TAPS];
   logic signed [31:0] w_q    [TAPS];
   logic signed [31:0] wrap_w;

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic signed [15:0] p_hist;
      logic signed [15:0] n_hist;
      logic signed [31:0] n_w;
      if (i == 0) begin : g_first
         assign p_hist = req_data.reference_sample;
      end else begin : g_mid
         assign p_hist = hist_q[i-1];
      end
      if (i == TAPS - 1) begin : g_tail
         assign n_hist = hist_q[0];
         assign n_w    = wrap_w;
      end else begin : g_body
         assign n_hist = hist_q[i+1];
         assign n_w    = w_q[i+1];
      end
      lms_anc_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .prev_hist   (p_hist),
         .next_hist   (n_hist),
         .next_weight (n_w),
         .hist        (hist_q[i]),
         .weight      (w_q[i])
      );
   end

   // registers
   lms_state_type       state_ff, state_in;
   logic [TC_W-1:0]     tap_cnt_ff, tap_cnt_in;
   logic [CNT_W-1:0]    frm_cnt_ff, frm_cnt_in;
   logic [15:0]         step_ff;
   logic signed [15:0]  prim_ff, prim_in;
   logic signed [47:0]  prod_ff;
   logic                prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [15:0]  err_ff, err_in;
   logic signed [32:0]  mu_err_ff;
   logic [31:0]         sq_ff;
   logic signed [48:0]  upd_ff;
   logic [39:0]         sum_ff, sum_in;
   logic                rsp_valid_ff;
   lms_rsp_type         rsp_ff, rsp_in;
   logic                load_rsp;

   // prediction rounding and error
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] pred_sh;
   logic signed [17:0]      pred_cl;
   logic signed [17:0]      diff;
   // weight update
   logic signed [48:0]      upd_rnd;
   logic signed [31:0]      delta;
   logic signed [32:0]      w_sum;
   logic signed [31:0]      w_new;
   // frame statistics
   logic [40:0]             sum_add;
   logic [39:0]             sum_sat;
   logic [39:0]             mean_raw;
   logic                    frame_last;

   always_comb begin
      rnd     = acc_ff + (ACC_W'(1) <<< 28);
      pred_sh = rnd >>> 29;
      if (pred_sh < -ACC_W'(65536)) begin
         pred_cl = -18'sd65536;
      end else if (pred_sh > ACC_W'(65536)) begin
         pred_cl = 18'sd65536;
      end else begin
         pred_cl = pred_sh[17:0];
      end
      diff = 18'(prim_ff) - pred_cl;
      if (diff < -18'sd32768) begin
         err_in = -16'sd32768;
      end else if (diff > 18'sd32767) begin
         err_in = 16'sd32767;
      end else begin
         err_in = diff[15:0];
      end
   end

   always_comb begin
      upd_rnd = upd_ff + 49'sd65536;
      delta   = 32'(upd_rnd >>> 17);
      w_sum   = 33'(w_q[0]) + 33'(delta);
      if (w_sum > 33'sd2147483647) begin
         w_new = 32'sh7fffffff;
      end else if (w_sum < -33'sd2147483648) begin
         w_new = 32'sh80000000;
      end else begin
         w_new = w_sum[31:0];
      end
      wrap_w = (state_ff == ST_UPD_WR) ? w_new : w_q[0];
   end

   always_comb begin
      sum_add    = {1'b0, sum_ff} + 41'(sq_ff);
      sum_sat    = sum_add[40] ? '1 : sum_add[39:0];
      mean_raw   = sum_sat >> MEAN_SH;
      frame_last = (frm_cnt_ff == CNT_W'(FRAME_LEN - 1));
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      tap_cnt_in = tap_cnt_ff;
      frm_cnt_in = frm_cnt_ff;
      prim_in    = prim_ff;
      acc_in     = acc_ff;
      sum_in     = sum_ff;
      cell_ctl   = '0;
      load_rsp   = 1'b0;
      rsp_in     = rsp_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cell_ctl.shift = 1'b1;
               prim_in        = req_data.primary_sample;
               acc_in         = '0;
               tap_cnt_in     = '0;
               state_in       = ST_PRED;
            end
         end
         ST_PRED: begin
            cell_ctl.rotate = 1'b1;
            tap_cnt_in      = tap_cnt_ff + 1'b1;
            if (tap_cnt_ff == TC_W'(TAPS - 1)) begin
               tap_cnt_in = '0;
               state_in   = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_ERR;
         ST_ERR:   state_in = ST_MUL;
         ST_MUL:   state_in = ST_UPD_MUL;
         ST_UPD_MUL: state_in = ST_UPD_WR;
         ST_UPD_WR: begin
            cell_ctl.rotate = 1'b1;
            tap_cnt_in      = tap_cnt_ff + 1'b1;
            state_in        = ST_UPD_MUL;
            if (tap_cnt_ff == TC_W'(TAPS - 1)) begin
               tap_cnt_in = '0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp              = 1'b1;
               rsp_in.error_sample   = err_ff;
               rsp_in.frame_done     = frame_last;
               rsp_in.frame_mean_sq_error = '0;
               if (frame_last) begin
                  rsp_in.frame_mean_sq_error = (mean_raw > 40'h007fffffff) ?
                     31'h7fffffff : mean_raw[30:0];
                  sum_in     = '0;
                  frm_cnt_in = '0;
               end else begin
                  sum_in     = sum_sat;
                  frm_cnt_in = frm_cnt_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_cnt_ff   <= '0;
         frm_cnt_ff   <= '0;
         sum_ff       <= '0;
         step_ff      <= STEP_SIZE_RESET;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         tap_cnt_ff  <= tap_cnt_in;
         frm_cnt_ff  <= frm_cnt_in;
         sum_ff      <= sum_in;
         prod_vld_ff <= (state_ff == ST_PRED);
         if (csr_wr_en) begin
            step_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prim_ff   <= prim_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      prod_ff   <= w_q[0] * hist_q[0];
      if (state_ff == ST_ERR) begin
         err_ff <= err_in;
      end
      if (state_ff == ST_MUL) begin
         mu_err_ff <= $signed({1'b0, step_ff}) * err_ff;
         sq_ff     <= 32'(err_ff * err_ff);
      end
      upd_ff <= mu_err_ff * hist_q[0];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ASSERT_CLK(a_accept_starts, clock, reset, req_valid && !req_stall |=> state_ff == ST_PRED)
   `ASSERT_CLK(a_rsp_from_done, clock, reset, $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
   `ASSERT_CLK(a_tap_cnt_range, clock, reset, tap_cnt_ff <= TC_W'(TAPS - 1))
   `ASSERT_CLK(a_frame_mean_zero, clock, reset, rsp_valid && !rsp_data.frame_done |-> rsp_data.frame_mean_sq_error == '0)

endmodule

[hw/rtl/lms_anc_cell.sv]
// ----------------------------------------------------------------------------
// lms_anc_cell
// one tap: a history sample and its weight, passed along the ring
// ----------------------------------------------------------------------------
module lms_anc_cell
   import lms_anc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  lms_cell_ctl_type   ctl,
   input  logic signed [15:0] prev_hist,
   input  logic signed [15:0] next_hist,
   input  logic signed [31:0] next_weight,
   output logic signed [15:0] hist,
   output logic signed [31:0] weight
);

   logic signed [15:0] hist_ff;
   logic signed [15:0] hist_in;
   logic signed [31:0] weight_ff;
   logic signed [31:0] weight_in;

   // shift inserts history, rotate circulates the whole tap
   always_comb begin
      hist_in   = hist_ff;
      weight_in = weight_ff;
      if (ctl.shift) begin
         hist_in = prev_hist;
      end else if (ctl.rotate) begin
         hist_in   = next_hist;
         weight_in = next_weight;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         weight_ff <= '0;
      end else begin
         hist_ff   <= hist_in;
         weight_ff <= weight_in;
      end
   end

   assign hist   = hist_ff;
   assign weight = weight_ff;

endmodule
